@@ src/vlom_pkg.sv @@
`default_nettype none

package vlom_pkg;

    // input modes; any other code is served as a query
    localparam logic [1:0] MODE_OBSERVE = 2'd0;
    localparam logic [1:0] MODE_DRAIN   = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_HIT_INC   = 3'd0;
    localparam logic [2:0] CFG_MISS_INC  = 3'd1;
    localparam logic [2:0] CFG_LOWER     = 3'd2;
    localparam logic [2:0] CFG_UPPER     = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;

    // configuration reset values, Q8.8
    localparam logic [14:0]        HIT_INC_RST   = 15'd217;
    localparam logic signed [15:0] MISS_INC_RST  = -16'sd158;
    localparam logic signed [15:0] LOWER_RST     = -16'sd510;
    localparam logic signed [15:0] UPPER_RST     = 16'sd890;
    localparam logic signed [15:0] THRESHOLD_RST = 16'sd355;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one voxel entry of the map memory
    typedef struct packed {
        logic signed [15:0] log_odds;
        logic [15:0]        hits;
        logic [15:0]        obs;
    } voxel_t;

endpackage

`default_nettype wire

@@ src/vlom_ram.sv @@
`default_nettype none

module vlom_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/voxel_log_odds_occupancy_map.sv @@
// 3D voxel occupancy map with Q8.8 log-odds per voxel and a deferred-update queue. Each voxel
// entry (log-odds, hit count, observation count) sits in one single-port-write map memory with
// registered read, and the block works on one item at a time. An observe reads its entry
// and writes it back; a query only reads it. A drain of a queued index takes the steps queue
// memory read, map read, step and skip decision, clamp and write back; a drain on an empty
// queue reads neither memory. Each item loads its result word in its last step, and a result
// that waits on out_ready holds the block in that step. After reset the block sweeps the map
// memory to zero, one entry per cycle; in_ready stays low during the sweep while configuration
// writes are taken as usual. The next item is accepted while the previous result word still
// waits in the output register.

`default_nettype none

module voxel_log_odds_occupancy_map
    import vlom_pkg::*;
#(
    parameter int SIZE_X      = 32,
    parameter int SIZE_Y      = 32,
    parameter int SIZE_Z      = 32,
    parameter int QUEUE_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // item input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [4:0]  vx,
    input  wire logic [4:0]  vy,
    input  wire logic [4:0]  vz,
    input  wire logic        occ,

    // result output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [14:0]      cell_index,
    output logic             occupied,
    output logic             applied,
    output logic             queue_empty,
    output logic             queue_overflow,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CELL_TOTAL = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int CAW        = $clog2(CELL_TOTAL);
    localparam int QAW        = $clog2(QUEUE_DEPTH);
    localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
    localparam int VW         = $bits(voxel_t);

    typedef enum logic [2:0] {
        S_CLEAR,   // zero sweep of the map memory after reset
        S_IDLE,    // waiting for an item
        S_VOXEL,   // observe or query: map word available
        S_EMPTY,   // drain on an empty queue
        S_DFIFO,   // drain: queue word available, map read issued
        S_DREAD,   // drain: map word available, step decision
        S_DWRITE   // drain: clamp, write back, result
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [14:0]        hit_inc_reg;
    logic signed [15:0] miss_inc_reg;
    logic signed [15:0] lower_reg;
    logic signed [15:0] upper_reg;
    logic signed [15:0] thresh_reg;

    // item context
    logic [1:0]     mode_reg;
    logic           occ_reg;
    logic [CAW-1:0] cell_reg;
    logic [CAW-1:0] clr_addr_reg;

    // queue pointers
    logic [QAW-1:0] head_reg;
    logic [QAW-1:0] tail_reg;
    logic [QCW-1:0] count_reg;

    // drain step terms
    logic signed [15:0] cur_reg;
    logic signed [16:0] sum_reg;
    logic               skip_reg;

    // output word
    logic        out_valid_reg;
    logic [14:0] cell_index_reg;
    logic        occupied_reg;
    logic        applied_reg;
    logic        queue_empty_reg;
    logic        queue_overflow_reg;

    // memory ports
    logic           vox_we;
    logic [CAW-1:0] vox_waddr;
    voxel_t         vox_wdata;
    logic           vox_re;
    logic [CAW-1:0] vox_raddr;
    voxel_t         vox_rd;
    logic [VW-1:0]  vox_rdata;

    logic           fifo_we;
    logic           fifo_re;
    logic [CAW-1:0] fifo_rdata;

    // ------------------------------------------------------------------
    // coordinate to linear index, out of range coordinates saturate
    // ------------------------------------------------------------------
    logic [4:0]     x_c;
    logic [4:0]     y_c;
    logic [4:0]     z_c;
    logic [CAW-1:0] cell_in;

    always_comb
    begin
        x_c = (32'(vx) >= 32'(SIZE_X)) ? 5'(SIZE_X - 1) : vx;
        y_c = (32'(vy) >= 32'(SIZE_Y)) ? 5'(SIZE_Y - 1) : vy;
        z_c = (32'(vz) >= 32'(SIZE_Z)) ? 5'(SIZE_Z - 1) : vz;
        cell_in = CAW'(x_c) * CAW'(SIZE_Y * SIZE_Z) + CAW'(y_c) * CAW'(SIZE_Z) + CAW'(z_c);
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_accept;
    logic slot_free;
    logic load_out;
    logic fifo_full;
    logic fifo_empty;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    // the output register is free or is emptied at this edge
    assign slot_free  = !out_valid_reg || out_ready;
    assign load_out   = slot_free &&
                        (state_reg == S_VOXEL || state_reg == S_EMPTY || state_reg == S_DWRITE);
    assign fifo_full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign fifo_empty = (count_reg == '0);

    logic [QAW-1:0] head_inc;
    logic [QAW-1:0] tail_inc;

    assign head_inc = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign vox_rd = voxel_t'(vox_rdata);

    // ------------------------------------------------------------------
    // observe and query terms
    // ------------------------------------------------------------------
    logic               is_observe;
    logic [15:0]        obs_inc;
    logic [15:0]        hits_inc;
    logic signed [15:0] rd_log;

    assign is_observe = (mode_reg == MODE_OBSERVE);
    assign rd_log     = vox_rd.log_odds;
    // both counters saturate
    assign obs_inc    = (vox_rd.obs != COUNT_MAX) ? vox_rd.obs + 16'd1 : vox_rd.obs;
    assign hits_inc   = (occ_reg && vox_rd.hits != COUNT_MAX) ? vox_rd.hits + 16'd1
                                                              : vox_rd.hits;

    // ------------------------------------------------------------------
    // drain step decision, from the map word
    // ------------------------------------------------------------------
    logic               hit_wins;
    logic signed [15:0] step;
    logic               dup_entry;
    logic               at_bound;
    logic signed [16:0] sum_next;

    always_comb
    begin
        // hits >= misses, written as 2*hits >= observations
        hit_wins  = ({vox_rd.hits, 1'b0} >= {1'b0, vox_rd.obs});
        step      = hit_wins ? signed'({1'b0, hit_inc_reg}) : miss_inc_reg;
        // a repeated index whose counters were cleared by an earlier drain
        dup_entry = (vox_rd.hits == '0) && (vox_rd.obs == '0);
        at_bound  = (!step[15] && rd_log >= upper_reg) ||
                    ((step[15] || step == '0) && rd_log <= lower_reg);
        sum_next  = 17'(rd_log) + 17'(step);
    end

    // ------------------------------------------------------------------
    // drain clamp and write back terms
    // ------------------------------------------------------------------
    logic signed [16:0] lower_ext;
    logic signed [16:0] upper_ext;
    logic signed [16:0] clamp_lo;
    logic signed [16:0] clamped;
    logic signed [15:0] new_log;
    logic               drain_applied;

    always_comb
    begin
        lower_ext = 17'(lower_reg);
        upper_ext = 17'(upper_reg);
        clamp_lo  = (sum_reg < lower_ext) ? lower_ext : sum_reg;
        // upper bound wins when the bounds cross
        clamped   = (clamp_lo > upper_ext) ? upper_ext : clamp_lo;
        new_log   = skip_reg ? cur_reg : clamped[15:0];
        drain_applied = !skip_reg && (clamped[15:0] != cur_reg);
    end

    // ------------------------------------------------------------------
    // memory port control
    // ------------------------------------------------------------------
    always_comb
    begin
        vox_re    = (in_accept && mode != MODE_DRAIN) || (state_reg == S_DFIFO);
        vox_raddr = (state_reg == S_DFIFO) ? fifo_rdata : cell_in;
        fifo_re   = in_accept && (mode == MODE_DRAIN) && !fifo_empty;
        fifo_we   = (state_reg == S_VOXEL) && slot_free && is_observe && !fifo_full;

        vox_we    = 1'b0;
        vox_waddr = cell_reg;
        vox_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                vox_we    = 1'b1;
                vox_waddr = clr_addr_reg;
            end
            S_VOXEL:
            begin
                vox_we             = slot_free && is_observe;
                vox_wdata.log_odds = rd_log;
                vox_wdata.hits     = hits_inc;
                vox_wdata.obs      = obs_inc;
            end
            S_DWRITE:
            begin
                // counters clear on every drain of a queued index
                vox_we             = slot_free;
                vox_wdata.log_odds = new_log;
            end
            default:
            begin
                vox_we = 1'b0;
            end
        endcase
    end

    vlom_ram #(
        .WIDTH (VW),
        .DEPTH (CELL_TOTAL)
    ) u_map_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .re    (vox_re),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    vlom_ram #(
        .WIDTH (CAW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (cell_reg),
        .re    (fifo_re),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_inc_reg  <= HIT_INC_RST;
            miss_inc_reg <= MISS_INC_RST;
            lower_reg    <= LOWER_RST;
            upper_reg    <= UPPER_RST;
            thresh_reg   <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HIT_INC:   hit_inc_reg  <= cfg_data[14:0];
                CFG_MISS_INC:  miss_inc_reg <= cfg_data;
                CFG_LOWER:     lower_reg    <= cfg_data;
                CFG_UPPER:     upper_reg    <= cfg_data;
                CFG_THRESHOLD: thresh_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer, queue pointers and output word
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new word loaded at this edge keeps the register full
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == CAW'(CELL_TOTAL - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        mode_reg <= mode;
                        occ_reg  <= occ;
                        cell_reg <= cell_in;
                        if (mode != MODE_DRAIN)
                        begin
                            state_reg <= S_VOXEL;
                        end
                        else if (fifo_empty)
                        begin
                            state_reg <= S_EMPTY;
                        end
                        else
                        begin
                            head_reg  <= head_inc;
                            count_reg <= count_reg - 1'b1;
                            state_reg <= S_DFIFO;
                        end
                    end
                end
                S_VOXEL:
                begin
                    if (slot_free)
                    begin
                        if (is_observe && !fifo_full)
                        begin
                            tail_reg  <= tail_inc;
                            count_reg <= count_reg + 1'b1;
                        end
                        out_valid_reg      <= 1'b1;
                        cell_index_reg     <= 15'(cell_reg);
                        occupied_reg       <= (rd_log > thresh_reg);
                        applied_reg        <= 1'b0;
                        // an observe always leaves the queue non-empty
                        queue_empty_reg    <= !is_observe && fifo_empty;
                        queue_overflow_reg <= is_observe && fifo_full;
                        state_reg          <= S_IDLE;
                    end
                end
                S_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        cell_index_reg     <= '0;
                        occupied_reg       <= 1'b0;
                        applied_reg        <= 1'b0;
                        queue_empty_reg    <= 1'b1;
                        queue_overflow_reg <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                end
                S_DFIFO:
                begin
                    cell_reg  <= fifo_rdata;
                    state_reg <= S_DREAD;
                end
                S_DREAD:
                begin
                    cur_reg   <= rd_log;
                    sum_reg   <= sum_next;
                    skip_reg  <= dup_entry || at_bound;
                    state_reg <= S_DWRITE;
                end
                S_DWRITE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        cell_index_reg     <= 15'(cell_reg);
                        occupied_reg       <= (new_log > thresh_reg);
                        applied_reg        <= drain_applied;
                        queue_empty_reg    <= fifo_empty;
                        queue_overflow_reg <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_index     = cell_index_reg;
    assign occupied       = occupied_reg;
    assign applied        = applied_reg;
    assign queue_empty    = queue_empty_reg;
    assign queue_overflow = queue_overflow_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // outside the sweep the map is written only together with a result word
    a_write_with_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (vox_we && state_reg != S_CLEAR) |-> load_out
    ) else $error("map write without a result word");

    // a drain from a non-empty queue pops exactly one entry
    a_drain_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_DRAIN && !fifo_empty) |=>
            (count_reg == $past(count_reg) - 1'b1)
    ) else $error("drain did not pop one queue entry");

    // an empty queue has its pointers together
    a_empty_ptrs: assert property (
        @(posedge clk) disable iff (!rst_n)
        fifo_empty |-> (head_reg == tail_reg)
    ) else $error("queue pointers apart while empty");

    // the fill count never passes the queue depth
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QUEUE_DEPTH)
    ) else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ verif/tb_voxel_log_odds_occupancy_map.sv @@
`default_nettype none

module tb_voxel_log_odds_occupancy_map;
    import vlom_pkg::*;

    localparam int CELLS  = 32768;
    localparam int QDEPTH = 1024;
    // timeout, far above the slowest passing run (sweep, stalls)
    localparam int LIMIT  = 200_000;

    // mode 3 has no name in the package, the block serves it as a query
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // register index with no register behind it
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // one result word as seen on the output port
    typedef struct packed {
        logic [14:0] cell_no;
        logic        occupied;
        logic        applied;
        logic        empty;
        logic        overflow;
    } map_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // one line of the directed table: an input word or a register write
    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  op;
        logic [4:0]  x;
        logic [4:0]  y;
        logic [4:0]  z;
        logic        o;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic        typed;
        map_result_t want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic [4:0]  vx = '0;
    logic [4:0]  vy = '0;
    logic [4:0]  vz = '0;
    logic        occ = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [14:0] cell_index;
    logic        occupied;
    logic        applied;
    logic        queue_empty;
    logic        queue_overflow;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // when set, neither side idles
    logic        quiet = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // words the block still owes, oldest first
    map_result_t awaited_words [$];

    // shadow of the map: per-voxel log-odds and counters
    logic signed [15:0] map_lo   [CELLS];
    logic [15:0]        map_hits [CELLS];
    logic [15:0]        map_obs  [CELLS];
    // shadow of the deferred-update queue
    logic [14:0]        pend_cells [QDEPTH];
    int                 pend_head = 0;
    int                 pend_tail = 0;
    int                 pend_count = 0;

    // shadow of the registers
    logic [14:0]        cur_hit_step  = HIT_INC_RST;
    logic signed [15:0] cur_miss_step = MISS_INC_RST;
    logic signed [15:0] cur_floor     = LOWER_RST;
    logic signed [15:0] cur_ceiling   = UPPER_RST;
    logic signed [15:0] cur_threshold = THRESHOLD_RST;

    step_row_t dir_rows [$];

    voxel_log_odds_occupancy_map #(
        .SIZE_X      (32),
        .SIZE_Y      (32),
        .SIZE_Z      (32),
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .vx             (vx),
        .vy             (vy),
        .vz             (vz),
        .occ            (occ),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_index     (cell_index),
        .occupied       (occupied),
        .applied        (applied),
        .queue_empty    (queue_empty),
        .queue_overflow (queue_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // register write as the block sees it; unknown indexes are dropped
    function automatic void apply_cfg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_HIT_INC:   cur_hit_step  = data[14:0];
            CFG_MISS_INC:  cur_miss_step = data;
            CFG_LOWER:     cur_floor     = data;
            CFG_UPPER:     cur_ceiling   = data;
            CFG_THRESHOLD: cur_threshold = data;
            default:       ;
        endcase
    endfunction

    // advance the shadow map by one accepted word and return the word it must answer with
    function automatic map_result_t predict_map(input logic [1:0] m, input logic [4:0] x,
                                                input logic [4:0] y, input logic [4:0] z,
                                                input logic o);
        map_result_t r;
        logic [14:0] c;
        logic        looked;
        int          step;
        int          cur;
        int          nv;
        r = '0;
        looked = 1'b1;
        // 32 per axis: a 5 bit coordinate never needs clamping, index is x:y:z
        c = {x, y, z};
        if (m == MODE_OBSERVE)
        begin
            if (map_obs[c] != COUNT_MAX)
                map_obs[c] = map_obs[c] + 16'd1;
            if (o && map_hits[c] != COUNT_MAX)
                map_hits[c] = map_hits[c] + 16'd1;
            if (pend_count == QDEPTH)
                r.overflow = 1'b1;
            else
            begin
                pend_cells[pend_tail] = c;
                pend_tail = (pend_tail + 1) % QDEPTH;
                pend_count++;
            end
        end
        else if (m == MODE_DRAIN)
        begin
            c = '0;
            looked = (pend_count != 0);
            if (pend_count != 0)
            begin
                c = pend_cells[pend_head];
                pend_head = (pend_head + 1) % QDEPTH;
                pend_count--;
                // both counters zero: a duplicate entry, nothing to apply
                if (map_hits[c] != 0 || map_obs[c] != 0)
                begin
                    step = (2 * int'(map_hits[c]) >= int'(map_obs[c])) ?
                           int'(cur_hit_step) : int'(cur_miss_step);
                    cur = int'(map_lo[c]);
                    map_hits[c] = '0;
                    map_obs[c] = '0;
                    if (!((step >= 0 && cur >= int'(cur_ceiling)) ||
                          (step <= 0 && cur <= int'(cur_floor))))
                    begin
                        nv = cur + step;
                        if (nv < int'(cur_floor))
                            nv = int'(cur_floor);
                        // crossed bounds end on the upper one
                        if (nv > int'(cur_ceiling))
                            nv = int'(cur_ceiling);
                        if (nv != cur)
                        begin
                            map_lo[c] = 16'(nv);
                            r.applied = 1'b1;
                        end
                    end
                end
            end
        end
        r.cell_no = c;
        r.occupied = looked && (int'(map_lo[c]) > int'(cur_threshold));
        r.empty = (pend_count == 0);
        return r;
    endfunction

    function automatic step_row_t row_item(input logic [1:0] m, input logic [4:0] x,
                                           input logic [4:0] y, input logic [4:0] z,
                                           input logic o);
        step_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = m;
        r.x = x;
        r.y = y;
        r.z = z;
        r.o = o;
        return r;
    endfunction

    // input word whose answer is typed in the table
    function automatic step_row_t row_chk(input logic [1:0] m, input logic [4:0] x,
                                          input logic [4:0] y, input logic [4:0] z,
                                          input logic o, input logic [14:0] c,
                                          input logic od, input logic ap,
                                          input logic em, input logic ov);
        step_row_t r;
        r = row_item(m, x, y, z, o);
        r.typed = 1'b1;
        r.want.cell_no = c;
        r.want.occupied = od;
        r.want.applied = ap;
        r.want.empty = em;
        r.want.overflow = ov;
        return r;
    endfunction

    function automatic step_row_t row_cfg(input logic [2:0] idx, input logic [15:0] data);
        step_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = data;
        return r;
    endfunction

    // offer one input word, idling first at random; the shadow moves on acceptance
    task automatic push_item(input logic [1:0] m, input logic [4:0] x, input logic [4:0] y,
                             input logic [4:0] z, input logic o, input logic typed,
                             input map_result_t fixed);
        map_result_t got;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        vx <= x;
        vy <= y;
        vz <= z;
        occ <= o;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = predict_map(m, x, y, z, o);
        awaited_words.push_back(typed ? fixed : got);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering words, let every owed word come back, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // receiver side stalls at random unless quiet
    always @(negedge clk)
    begin
        out_ready <= quiet || ($urandom_range(99) >= 33);
    end

    // result checker, oldest expectation first
    always @(posedge clk)
    begin : check_word
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("result word with nothing expected, cell_index %0d", cell_index);
                mismatch_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (cell_index !== want.cell_no)
                begin
                    $error("cell_index: expected %0d, got %0d", want.cell_no, cell_index);
                    mismatch_count++;
                end
                if (occupied !== want.occupied)
                begin
                    $error("occupied: expected %0d, got %0d", want.occupied, occupied);
                    mismatch_count++;
                end
                if (applied !== want.applied)
                begin
                    $error("applied: expected %0d, got %0d", want.applied, applied);
                    mismatch_count++;
                end
                if (queue_empty !== want.empty)
                begin
                    $error("queue_empty: expected %0d, got %0d", want.empty, queue_empty);
                    mismatch_count++;
                end
                if (queue_overflow !== want.overflow)
                begin
                    $error("queue_overflow: expected %0d, got %0d", want.overflow,
                           queue_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int                 i;
        int                 phase;
        int                 n;
        int                 r;
        int                 hit_pct;
        logic [14:0]        pool [6];
        logic [14:0]        pick;
        logic [1:0]         m;
        logic               o;
        logic [14:0]        hi_v;
        logic signed [15:0] mi_v;
        logic signed [15:0] lo_v;
        logic signed [15:0] up_v;
        logic signed [15:0] th_v;
        step_row_t          row;

        for (i = 0; i < CELLS; i++)
        begin
            map_lo[i] = '0;
            map_hits[i] = '0;
            map_obs[i] = '0;
        end

        // directed part, reset values in force
        // drain on an empty queue ignores the coordinates
        dir_rows.push_back(row_chk(MODE_DRAIN, 5'd31, 5'd31, 5'd31, 1'b1,
                                   15'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(row_chk(MODE_QUERY, 5'd31, 5'd31, 5'd31, 1'b1,
                                   15'd32767, 1'b0, 1'b0, 1'b1, 1'b0));
        // mode 3 answers as a query
        dir_rows.push_back(row_chk(MODE_SPARE, 5'd0, 5'd0, 5'd0, 1'b0,
                                   15'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(row_chk(MODE_OBSERVE, 5'd31, 5'd0, 5'd31, 1'b1,
                                   15'd31775, 1'b0, 1'b0, 1'b0, 1'b0));
        // one hit step: 217, still under the threshold
        dir_rows.push_back(row_chk(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0,
                                   15'd31775, 1'b0, 1'b1, 1'b1, 1'b0));
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd31, 5'd0, 5'd31, 1'b0));
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd31, 5'd0, 5'd31, 1'b0));
        // misses win, then the second entry is a duplicate
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd3, 5'd7, 5'd9, 1'b1));
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0));
        // widest steps and bounds; bit 15 of the hit step write is dropped
        dir_rows.push_back(row_cfg(CFG_HIT_INC, 16'hFFFF));
        dir_rows.push_back(row_cfg(CFG_MISS_INC, 16'h8000));
        dir_rows.push_back(row_cfg(CFG_LOWER, 16'h8000));
        dir_rows.push_back(row_cfg(CFG_UPPER, 16'h7FFF));
        dir_rows.push_back(row_cfg(CFG_THRESHOLD, 16'h8000));
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b1));
        dir_rows.push_back(row_chk(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0,
                                   15'd1091, 1'b1, 1'b1, 1'b1, 1'b0));
        // already at the upper bound: skipped
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b1));
        dir_rows.push_back(row_chk(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0,
                                   15'd1091, 1'b1, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b0));
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0));
        // miss step past the lower bound clamps
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b0));
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0));
        // already at the lower bound: skipped
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b0));
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0));
        // crossed bounds, clamp ends on the upper one
        dir_rows.push_back(row_cfg(CFG_HIT_INC, 16'd1));
        dir_rows.push_back(row_cfg(CFG_LOWER, 16'd100));
        dir_rows.push_back(row_cfg(CFG_UPPER, -16'sd100));
        dir_rows.push_back(row_cfg(CFG_THRESHOLD, 16'h7FFF));
        dir_rows.push_back(row_cfg(CFG_UNUSED, 16'hA5A5));
        dir_rows.push_back(row_item(MODE_OBSERVE, 5'd1, 5'd2, 5'd3, 1'b1));
        dir_rows.push_back(row_item(MODE_DRAIN, 5'd0, 5'd0, 5'd0, 1'b0));
        dir_rows.push_back(row_item(MODE_QUERY, 5'd1, 5'd2, 5'd3, 1'b0));

        // reset first; the block then sweeps its map on its own
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                cfg_write(row.reg_idx, row.reg_val);
            end
            else
                push_item(row.op, row.x, row.y, row.z, row.o, row.typed, row.want);
        end

        // random phases, one register setting each
        for (phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    hi_v = HIT_INC_RST;
                    mi_v = MISS_INC_RST;
                    lo_v = LOWER_RST;
                    up_v = UPPER_RST;
                    th_v = THRESHOLD_RST;
                end
                1:
                begin
                    // zero steps: nothing can move
                    hi_v = '0;
                    mi_v = '0;
                    lo_v = 16'h8000;
                    up_v = 16'h7FFF;
                    th_v = '0;
                end
                2:
                begin
                    hi_v = 15'h7FFF;
                    mi_v = 16'h8000;
                    lo_v = 16'h8000;
                    up_v = 16'h7FFF;
                    th_v = 16'(int'($urandom_range(1000)) - 500);
                end
                default:
                begin
                    hi_v = 15'($urandom_range(600, 1));
                    mi_v = 16'(-int'($urandom_range(600, 1)));
                    lo_v = 16'(-int'($urandom_range(3000)));
                    up_v = 16'($urandom_range(3000));
                    if ($urandom_range(3) == 0)
                        {lo_v, up_v} = {up_v, lo_v};
                    th_v = 16'(int'($urandom_range(1000)) - 500);
                end
            endcase
            cfg_write(CFG_HIT_INC, {1'($urandom_range(1)), hi_v});
            cfg_write(CFG_MISS_INC, mi_v);
            cfg_write(CFG_LOWER, lo_v);
            cfg_write(CFG_UPPER, up_v);
            cfg_write(CFG_THRESHOLD, th_v);

            // one phase runs at full rate on both sides
            quiet = (phase == 3);
            hit_pct = $urandom_range(80, 20);
            // small working set so counts pile up and bounds get reached
            for (i = 0; i < 6; i++)
                pool[i] = 15'($urandom);

            for (n = 0; n < 150; n++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    m = MODE_OBSERVE;
                else if (r < 85)
                    m = MODE_DRAIN;
                else if (r < 95)
                    m = MODE_QUERY;
                else
                    m = MODE_SPARE;
                if ($urandom_range(3) != 0)
                    pick = pool[$urandom_range(5)];
                else
                    pick = 15'($urandom);
                o = ($urandom_range(99) < hit_pct);
                push_item(m, pick[14:10], pick[9:5], pick[4:0], o, 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ voxel_log_odds_occupancy_map.f @@
src/vlom_pkg.sv
src/vlom_ram.sv
src/voxel_log_odds_occupancy_map.sv
verif/tb_voxel_log_odds_occupancy_map.sv
